// File: hw/rtl/temporal_recursive_denoise_defines.svh
// ----------------------------------------------------------------------------
// Temporal recursive denoise - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_RECURSIVE_DENOISE_DEFINES_SVH
`define TEMPORAL_RECURSIVE_DENOISE_DEFINES_SVH

// same-cycle implication
`define TRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/trd_pkg.sv
// ----------------------------------------------------------------------------
// Temporal recursive denoise - package
// Fixed widths, register indices and reset values shared by the block.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int SAMPLE_BITS  = 8;
    localparam int WEIGHT_BITS  = 17;
    localparam int WEIGHT_SHIFT = 16;
    localparam int THRESH_W     = 8;
    localparam int COMP_W       = 3;
    localparam int FRAME_W      = 21;
    localparam int ENABLE_W     = 4;
    localparam int CHAN_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 21;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [COMP_W-1:0]      COMP_MAX   = 3'd4;

    localparam logic [WEIGHT_BITS-1:0] RST_BLEND_WEIGHT = 17'd32768;
    localparam logic [THRESH_W-1:0]    RST_THRESHOLD    = 8'd25;
    localparam logic                   RST_REPLACE_MODE = 1'b0;
    localparam logic [ENABLE_W-1:0]    RST_CHAN_ENABLE  = 4'hf;
    localparam logic [COMP_W-1:0]      RST_COMPONENTS   = 3'd3;
    localparam logic [FRAME_W-1:0]     RST_FRAME_SAMPLES = 21'h100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_WEIGHT  = 3'd0,
        CFG_THRESHOLD     = 3'd1,
        CFG_REPLACE_CLOSE = 3'd2,
        CFG_CHAN_ENABLE   = 3'd3,
        CFG_COMPONENTS    = 3'd4,
        CFG_FRAME_SAMPLES = 3'd5
    } t_cfg_reg;

endpackage

// File: hw/rtl/trd_acc_store.sv
// ----------------------------------------------------------------------------
// Temporal recursive denoise - accumulator store
// Single-port-write, registered-read memory with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module trd_acc_store #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1048576
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    output logic                       o_clear_busy
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clr_busy;

endmodule

// File: hw/rtl/temporal_recursive_denoise.sv
// ----------------------------------------------------------------------------
// Temporal recursive denoise - top level
// Per-position accumulator blend with threshold replace, raster-order input.
//
//   Port group   Direction  Handshake                   Payload
//   in           in         i_in_valid / o_in_ready     i_sample
//   out          out        o_out_valid / i_out_ready   o_filtered_sample, o_was_replaced
//   cfg          in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One transfer per cycle, unless a same-position hazard, the store clear or a full pipe holds the input.
// Stages: store read, blend multiply, add/compare/write-back into output register.
// Back-to-back enabled samples at the same position (frame of 1) hold the input until the write-back.
// After reset the store is zeroed address by address; no input transfer until that is done.
// A full output register stalls the pipe from the back; earlier stages keep filling.
// ----------------------------------------------------------------------------
`include "temporal_recursive_denoise_defines.svh"

module temporal_recursive_denoise #(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [trd_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [trd_pkg::SAMPLE_BITS-1:0]    o_filtered_sample,
    output logic                               o_was_replaced,
    input  logic                               i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int ACC_W   = trd_pkg::SAMPLE_BITS + FRAC_BITS;
    localparam int DELTA_W = ACC_W + 1;
    localparam int PROD_W  = DELTA_W + trd_pkg::WEIGHT_BITS + 1;
    localparam int CMP_W   = (ADDR_W + 1 > trd_pkg::FRAME_W + 1) ?
                             ADDR_W + 1 : trd_pkg::FRAME_W + 1;
    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_SAMPLES);

    // configuration
    logic [trd_pkg::WEIGHT_BITS-1:0] r_blend_weight;
    logic [trd_pkg::THRESH_W-1:0]    r_threshold;
    logic                            r_replace_close;
    logic [trd_pkg::ENABLE_W-1:0]    r_chan_enable;
    logic [trd_pkg::COMP_W-1:0]      r_components;
    logic [trd_pkg::FRAME_W-1:0]     r_frame_samples;

    // counters
    logic [ADDR_W-1:0]               r_position;
    logic [trd_pkg::CHAN_W-1:0]      r_channel;

    // stage 1: store read in flight
    logic                            r_s1_valid;
    logic                            r_s1_en;
    logic [ADDR_W-1:0]               r_s1_addr;
    logic [trd_pkg::SAMPLE_BITS-1:0] r_s1_sample;

    // stage 2: product ready
    logic                            r_s2_valid;
    logic                            r_s2_en;
    logic [ADDR_W-1:0]               r_s2_addr;
    logic [trd_pkg::SAMPLE_BITS-1:0] r_s2_sample;
    logic [ACC_W-1:0]                r_s2_acc;
    logic signed [PROD_W-1:0]        r_s2_prod;

    // last write-back, for forwarding
    logic                            r_wb_valid;
    logic [ADDR_W-1:0]               r_wb_addr;
    logic [ACC_W-1:0]                r_wb_data;

    // output register
    logic                            r_out_valid;
    logic [trd_pkg::SAMPLE_BITS-1:0] r_out_sample;
    logic                            r_out_replaced;

    logic                            clear_busy;
    logic [ACC_W-1:0]                rd_data;
    logic                            out_free;
    logic                            s2_hold;
    logic                            s2_move;
    logic                            s1_hold;
    logic                            s1_wr;
    logic                            hazard;
    logic                            in_accept;
    logic                            wr_en;

    logic [CMP_W-1:0]                frame_size;
    logic [CMP_W-1:0]                pos_next;
    logic [trd_pkg::COMP_W-1:0]      chan_count;
    logic [trd_pkg::COMP_W-1:0]      chan_next;

    logic [ACC_W-1:0]                s1_acc;
    logic [ACC_W-1:0]                s1_target;
    logic [trd_pkg::WEIGHT_BITS-1:0] w_sat;
    logic signed [DELTA_W-1:0]       s1_delta;
    logic signed [PROD_W-1:0]        s1_prod;

    logic signed [PROD_W-1:0]        s2_step_full;
    logic signed [DELTA_W-1:0]       s2_step;
    logic signed [DELTA_W-1:0]       s2_sum;
    logic [ACC_W-1:0]                s2_acc_new;
    logic [ACC_W-1:0]                s2_target;
    logic [ACC_W-1:0]                s2_diff;
    logic [ACC_W-1:0]                s2_limit;
    logic                            s2_replace;
    logic [ACC_W-1:0]                s2_wr_data;
    logic [trd_pkg::SAMPLE_BITS-1:0] s2_out_sample;
    logic                            s2_out_replaced;

    trd_acc_store #(
        .DATA_W (ACC_W),
        .DEPTH  (MAX_SAMPLES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (in_accept),
        .i_rd_addr    (r_position),
        .o_rd_data    (rd_data),
        .i_wr_en      (wr_en),
        .i_wr_addr    (r_s2_addr),
        .i_wr_data    (s2_wr_data),
        .o_clear_busy (clear_busy)
    );

    // ---- flow control
    always_comb begin
        out_free  = !r_out_valid || i_out_ready;
        s2_hold   = r_s2_valid && !out_free;
        s2_move   = r_s2_valid && out_free;
        s1_hold   = r_s1_valid && s2_hold;
        s1_wr     = r_s1_valid && r_s1_en;
        hazard    = (s1_wr && (r_s1_addr == r_position)) ||
                    (s2_hold && r_s2_en && (r_s2_addr == r_position));
        o_in_ready = !clear_busy && !s1_hold && !hazard;
        in_accept  = i_in_valid && o_in_ready;
        wr_en      = s2_move && r_s2_en;
    end

    // ---- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight  <= trd_pkg::RST_BLEND_WEIGHT;
            r_threshold     <= trd_pkg::RST_THRESHOLD;
            r_replace_close <= trd_pkg::RST_REPLACE_MODE;
            r_chan_enable   <= trd_pkg::RST_CHAN_ENABLE;
            r_components    <= trd_pkg::RST_COMPONENTS;
            r_frame_samples <= trd_pkg::RST_FRAME_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (trd_pkg::t_cfg_reg'(i_cfg_index))
                trd_pkg::CFG_BLEND_WEIGHT: begin
                    r_blend_weight <= i_cfg_data[trd_pkg::WEIGHT_BITS-1:0];
                end
                trd_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[trd_pkg::THRESH_W-1:0];
                end
                trd_pkg::CFG_REPLACE_CLOSE: begin
                    r_replace_close <= i_cfg_data[0];
                end
                trd_pkg::CFG_CHAN_ENABLE: begin
                    r_chan_enable <= i_cfg_data[trd_pkg::ENABLE_W-1:0];
                end
                trd_pkg::CFG_COMPONENTS: begin
                    r_components <= i_cfg_data[trd_pkg::COMP_W-1:0];
                end
                trd_pkg::CFG_FRAME_SAMPLES: begin
                    r_frame_samples <= i_cfg_data[trd_pkg::FRAME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- position and channel counters
    always_comb begin
        if ((r_frame_samples == '0) || (CMP_W'(r_frame_samples) > MAX_CNT)) begin
            frame_size = MAX_CNT;
        end else begin
            frame_size = CMP_W'(r_frame_samples);
        end
        pos_next = CMP_W'(r_position) + 1'b1;
        if ((r_components == '0) || (r_components > trd_pkg::COMP_MAX)) begin
            chan_count = trd_pkg::COMP_MAX;
        end else begin
            chan_count = r_components;
        end
        chan_next = trd_pkg::COMP_W'(r_channel) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_channel  <= '0;
        end else if (in_accept) begin
            r_position <= (pos_next >= frame_size) ? '0 : pos_next[ADDR_W-1:0];
            r_channel  <= (chan_next >= chan_count) ? '0 : chan_next[trd_pkg::CHAN_W-1:0];
        end
    end

    // ---- stage 1: forward, difference, multiply
    always_comb begin
        s1_acc    = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : rd_data;
        s1_target = {r_s1_sample, {FRAC_BITS{1'b0}}};
        w_sat     = r_blend_weight[trd_pkg::WEIGHT_BITS-1] ? trd_pkg::WEIGHT_ONE
                                                           : r_blend_weight;
        s1_delta  = signed'({1'b0, s1_target}) - signed'({1'b0, s1_acc});
        s1_prod   = signed'({1'b0, w_sat}) * s1_delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!s1_hold) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_en     <= r_chan_enable[r_channel];
            r_s1_addr   <= r_position;
            r_s1_sample <= i_sample;
        end
    end

    // ---- stage 2: accumulate, threshold, write back
    always_comb begin
        s2_step_full = r_s2_prod >>> trd_pkg::WEIGHT_SHIFT;
        s2_step      = s2_step_full[DELTA_W-1:0];
        s2_sum       = signed'({1'b0, r_s2_acc}) + s2_step;
        s2_acc_new   = s2_sum[ACC_W-1:0];
        s2_target    = {r_s2_sample, {FRAC_BITS{1'b0}}};
        s2_diff      = (s2_acc_new >= s2_target) ? (s2_acc_new - s2_target)
                                                 : (s2_target - s2_acc_new);
        s2_limit     = {r_threshold, {FRAC_BITS{1'b0}}};
        s2_replace   = r_replace_close ? (s2_diff < s2_limit) : (s2_diff > s2_limit);
        s2_wr_data   = s2_replace ? s2_target : s2_acc_new;
        if (!r_s2_en || s2_replace) begin
            s2_out_sample = r_s2_sample;
        end else begin
            s2_out_sample = s2_acc_new[ACC_W-1:FRAC_BITS];
        end
        s2_out_replaced = r_s2_en && s2_replace;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!s2_hold) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && !s2_hold) begin
            r_s2_en     <= r_s1_en;
            r_s2_addr   <= r_s1_addr;
            r_s2_sample <= r_s1_sample;
            r_s2_acc    <= s1_acc;
            r_s2_prod   <= s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (wr_en) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= r_s2_addr;
            r_wb_data <= s2_wr_data;
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_sample   <= s2_out_sample;
            r_out_replaced <= s2_out_replaced;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_was_replaced    = r_out_replaced;

    // ---- checks
    `TRD_ASSERT_IMP(a_no_transfer_in_clear, clear_busy, !o_in_ready, "transfer during clear")
    `TRD_ASSERT_IMP(a_no_write_in_clear, wr_en, !clear_busy, "write-back during clear")
    `TRD_ASSERT_IMP(a_no_raw_overlap, in_accept && s1_wr, r_s1_addr != r_position, "read overlaps pending write")
    `TRD_ASSERT_NXT(a_replace_passes, s2_move && s2_out_replaced, o_was_replaced && (o_filtered_sample == $past(r_s2_sample)), "replace did not pass sample")

endmodule

// File: tb/trd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Temporal recursive denoise - result checker
// Watches the register port and both streams, keeps its own copy of the
// per-position accumulators and settings, predicts each filtered component
// and compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
module trd_checker
    import trd_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [SAMPLE_BITS-1:0] i_filtered_sample,
    input  logic                   i_was_replaced,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_reloads
);

    localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
    localparam longint unsigned LEVEL_MAX = (64'd1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic                   replaced;
    } denoised_t;

    denoised_t denoised_q[$];
    bit [ACC_W-1:0] acc_mem [MAX_SAMPLES];

    logic [WEIGHT_BITS-1:0] weight_r;
    logic [THRESH_W-1:0]    thresh_r;
    logic                   close_r;
    logic [ENABLE_W-1:0]    enable_r;
    logic [COMP_W-1:0]      comps_r;
    logic [FRAME_W-1:0]     frame_r;
    int                     pos_r;
    int                     chan_r;
    int                     fail_cnt;
    int                     checked_cnt;
    int                     reload_cnt;

    initial begin
        fail_cnt     = 0;
        checked_cnt  = 0;
        reload_cnt   = 0;
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_reloads    = 0;
    end

    function automatic denoised_t denoise_component(input logic [SAMPLE_BITS-1:0] s);
        longint unsigned w, tgt, acc, diff, lim, ip;
        logic [CHAN_W-1:0] ch;
        logic              swap;
        denoised_t         r;
        int                span, nch;
        ch         = chan_r[CHAN_W-1:0];
        r.level    = s;
        r.replaced = 1'b0;
        if (enable_r[ch]) begin
            w = weight_r;
            if (w > WEIGHT_ONE) w = WEIGHT_ONE;
            tgt  = s;
            tgt  = tgt << FRAC_BITS;
            acc  = acc_mem[pos_r];
            acc  = ((WEIGHT_ONE - w) * acc + w * tgt) >> WEIGHT_SHIFT;
            diff = (acc >= tgt) ? acc - tgt : tgt - acc;
            lim  = thresh_r;
            lim  = lim << FRAC_BITS;
            swap = close_r ? (diff < lim) : (diff > lim);
            if (swap) begin
                acc        = tgt;
                r.replaced = 1'b1;
            end else begin
                ip      = acc >> FRAC_BITS;
                r.level = (ip > LEVEL_MAX) ? LEVEL_MAX[SAMPLE_BITS-1:0] : ip[SAMPLE_BITS-1:0];
            end
            acc_mem[pos_r] = acc[ACC_W-1:0];
        end
        span = frame_r;
        if (span == 0 || span > MAX_SAMPLES) span = MAX_SAMPLES;
        nch = comps_r;
        if (nch == 0 || nch > COMP_MAX) nch = COMP_MAX;
        pos_r  = (pos_r + 1 >= span) ? 0 : pos_r + 1;
        chan_r = (chan_r + 1 >= nch) ? 0 : chan_r + 1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        denoised_t got, want;
        if (!i_rst_n) begin
            weight_r = RST_BLEND_WEIGHT;
            thresh_r = RST_THRESHOLD;
            close_r  = RST_REPLACE_MODE;
            enable_r = RST_CHAN_ENABLE;
            comps_r  = RST_COMPONENTS;
            frame_r  = RST_FRAME_SAMPLES;
            pos_r    = 0;
            chan_r   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLEND_WEIGHT:  weight_r = i_cfg_data[WEIGHT_BITS-1:0];
                    CFG_THRESHOLD:     thresh_r = i_cfg_data[THRESH_W-1:0];
                    CFG_REPLACE_CLOSE: close_r  = i_cfg_data[0];
                    CFG_CHAN_ENABLE:   enable_r = i_cfg_data[ENABLE_W-1:0];
                    CFG_COMPONENTS:    comps_r  = i_cfg_data[COMP_W-1:0];
                    CFG_FRAME_SAMPLES: frame_r  = i_cfg_data[FRAME_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                denoised_q.push_back(denoise_component(i_sample));
            if (i_out_valid && i_out_ready) begin
                got = {i_filtered_sample, i_was_replaced};
                if (denoised_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t checker: result with nothing outstanding, level %0d reload %0b",
                                 $time, got.level, got.replaced);
                    fail_cnt++;
                end else begin
                    want = denoised_q.pop_front();
                    if (got != want) begin
                        if (fail_cnt < 10)
                            $display("%0t checker: result %0d level exp %0d got %0d, reload exp %0b got %0b",
                                     $time, checked_cnt, want.level, got.level,
                                     want.replaced, got.replaced);
                        fail_cnt++;
                    end
                    if (want.replaced) reload_cnt++;
                    checked_cnt++;
                end
            end
            o_pending    <= denoised_q.size();
            o_mismatches <= fail_cnt;
            o_checked    <= checked_cnt;
            o_reloads    <= reload_cnt;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Temporal recursive denoise - testbench top
// Drives register settings and component streams with random source gaps and
// sink stalls, waits out the store clearing after reset, and gives the
// verdict from the checker's mismatch count and outstanding results.
// ----------------------------------------------------------------------------
module tb;
    import trd_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_SAMPLES    = 1048576;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 700;
    localparam int TAIL_ITEMS     = 60;
    localparam int SCENE_SIZE     = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3 * MAX_SAMPLES;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic [WEIGHT_BITS-1:0] weight;
        logic [THRESH_W-1:0]    thresh;
        logic                   close;
        logic [ENABLE_W-1:0]    enable;
        logic [COMP_W-1:0]      comps;
        logic [FRAME_W-1:0]     frame;
    } denoise_setting_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_ready;
    logic [SAMPLE_BITS-1:0] filtered_sample;
    logic                   was_replaced;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches, pending, checked, reloads;
    int src_rate, sink_rate, sink_hold, quiet;
    int raster, span, sent, settings;
    logic [SAMPLE_BITS-1:0] scene [SCENE_SIZE];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    temporal_recursive_denoise #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_sample          (sample),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_filtered_sample (filtered_sample),
        .o_was_replaced    (was_replaced),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    trd_checker #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_sample          (sample),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_filtered_sample (filtered_sample),
        .i_was_replaced    (was_replaced),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_reloads         (reloads)
    );

    // sink: random stall bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold > 1) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_hold == 1) begin
            sink_hold <= 0;
            out_ready <= 1'b1;
        end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
            out_ready <= 1'b0;
            sink_hold <= $urandom_range(1, 17);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb: no transfer for %0d cycles, giving up", quiet);
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic load_setting(input denoise_setting_t c);
        logic [CFG_DATA_W-1:0] word;
        cfg_we    <= 1'b1;
        word       = CFG_DATA_W'($urandom);
        word[WEIGHT_BITS-1:0] = c.weight;
        cfg_index <= CFG_BLEND_WEIGHT;
        cfg_data  <= word;
        @(posedge clk);
        word       = CFG_DATA_W'($urandom);
        word[THRESH_W-1:0] = c.thresh;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= word;
        @(posedge clk);
        word       = CFG_DATA_W'($urandom);
        word[0]    = c.close;
        cfg_index <= CFG_REPLACE_CLOSE;
        cfg_data  <= word;
        @(posedge clk);
        word       = CFG_DATA_W'($urandom);
        word[ENABLE_W-1:0] = c.enable;
        cfg_index <= CFG_CHAN_ENABLE;
        cfg_data  <= word;
        @(posedge clk);
        word       = CFG_DATA_W'($urandom);
        word[COMP_W-1:0] = c.comps;
        cfg_index <= CFG_COMPONENTS;
        cfg_data  <= word;
        @(posedge clk);
        cfg_index <= CFG_FRAME_SAMPLES;
        cfg_data  <= c.frame;
        @(posedge clk);
        // unmapped indices must not disturb anything
        cfg_index <= CFG_SPARE_A;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_B;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        span = (c.frame == 0 || c.frame > MAX_SAMPLES) ? MAX_SAMPLES : c.frame;
        settings++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        raster = (raster + 1 >= span) ? 0 : raster + 1;
        sent++;
        if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // mostly a steady scene plus noise, with cuts and pure noise mixed in
    function automatic logic [SAMPLE_BITS-1:0] next_sample(input int k, input int amp);
        int v, pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return SAMPLE_BITS'($urandom);
        if (pick < 8) begin
            scene[k] = SAMPLE_BITS'($urandom);
            return scene[k];
        end
        v = int'(scene[k]) + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic denoise_setting_t draw_setting();
        denoise_setting_t c;
        case ($urandom_range(0, 7))
            0: c.weight = '0;
            1: c.weight = WEIGHT_ONE;
            2: c.weight = WEIGHT_BITS'($urandom_range(WEIGHT_ONE + 1, (1 << WEIGHT_BITS) - 1));
            3: c.weight = WEIGHT_BITS'(WEIGHT_ONE >> $urandom_range(1, 8));
            default: c.weight = WEIGHT_BITS'($urandom_range(256, WEIGHT_ONE));
        endcase
        case ($urandom_range(0, 5))
            0: c.thresh = '0;
            1: c.thresh = '1;
            2: c.thresh = THRESH_W'($urandom);
            default: c.thresh = THRESH_W'($urandom_range(0, 40));
        endcase
        c.close  = 1'($urandom_range(0, 1));
        c.enable = ($urandom_range(0, 9) < 7) ? RST_CHAN_ENABLE : ENABLE_W'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2:       c.comps = COMP_W'($urandom);
            3, 4, 5, 6, 7: c.comps = COMP_MAX;
            default:       c.comps = RST_COMPONENTS;
        endcase
        case ($urandom_range(0, 19))
            0, 1: c.frame = 21'd1;
            2:    c.frame = RST_FRAME_SAMPLES;
            3:    c.frame = '0;
            4:    c.frame = '1;
            5, 6: c.frame = FRAME_W'($urandom);
            default: c.frame = FRAME_W'($urandom_range(1, SCENE_SIZE));
        endcase
        return c;
    endfunction

    initial begin
        denoise_setting_t c;
        int n, amp;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BLEND_WEIGHT;
        cfg_data  = '0;
        src_rate  = 0;
        sink_rate = 0;
        sink_hold = 0;
        quiet     = 0;
        raster    = 0;
        span      = MAX_SAMPLES;
        sent      = 0;
        settings  = 0;
        foreach (scene[i]) scene[i] = SAMPLE_BITS'($urandom);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, mode flips, weight and size corner cases
        src_rate  = 20;
        sink_rate <= 20;
        load_setting('{17'd32768, 8'd255, 1'b0, 4'hf, 3'd4, 21'd4});
        send_sample(8'd0);   send_sample(8'd255); send_sample(8'd128); send_sample(8'd1);
        send_sample(8'd0);   send_sample(8'd255); send_sample(8'd129); send_sample(8'd1);
        drain();
        // weight above one saturates, bad components and frame size
        load_setting('{17'h1ffff, 8'd0, 1'b0, 4'hf, 3'd0, 21'd0});
        send_sample(8'd200); send_sample(8'd7);
        drain();
        // zero weight holds the accumulator, replace-when-close mode
        load_setting('{17'd0, 8'd255, 1'b1, 4'h5, 3'd7, 21'h1fffff});
        send_sample(8'd255); send_sample(8'd255); send_sample(8'd0); send_sample(8'd0);
        drain();
        // frame of one: same position back to back
        load_setting('{17'd256, 8'd0, 1'b1, 4'ha, 3'd4, 21'd1});
        send_sample(8'd50);  send_sample(8'd50);  send_sample(8'd60); send_sample(8'd60);
        drain();
        load_setting('{17'h10000, 8'd10, 1'b0, 4'hf, 3'd3, 21'h100000});
        send_sample(8'd90);  send_sample(8'd91);  send_sample(8'd92); send_sample(8'd93);
        drain();
        // shrink the frame below the current position
        load_setting('{17'd16384, 8'd3, 1'b0, 4'h0, 3'd3, 21'd2});
        send_sample(8'd170); send_sample(8'd85);  send_sample(8'd33);
        drain();

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS - TAIL_ITEMS) begin
            c   = draw_setting();
            amp = $urandom_range(0, 24);
            src_rate  = $urandom_range(0, 2) * 15;
            sink_rate <= $urandom_range(0, 2) * 15;
            load_setting(c);
            n = (c.frame == 1) ? $urandom_range(10, 30) : $urandom_range(20, 80);
            repeat (n) send_sample(next_sample(raster % SCENE_SIZE, amp));
            drain();
        end

        // closing stretch at full rate
        src_rate  = 0;
        sink_rate <= 0;
        c = draw_setting();
        c.frame = 21'd12;
        load_setting(c);
        // let any sink stall burst run out first
        while (sink_hold != 0 || !out_ready) @(posedge clk);
        repeat (TAIL_ITEMS) send_sample(next_sample(raster % SCENE_SIZE, 8));
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d components over %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("tb: %0d of them reloaded the accumulator from the input", reloads);
        if (mismatches == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
